// ----- rtl/bple_pkg.sv -----
// Shared types and constants for the bounded positional list engine.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package bple_pkg;

   // Field widths fixed by the interface.
   localparam int KIND_W = 3;
   localparam int VAL_W  = 32;
   localparam int POS_W  = 6;
   localparam int LEN_W  = 7;
   localparam int STAT_W = 2;

   // Command kinds.
   localparam logic [KIND_W-1:0] KIND_INSERT   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_DEL_POS  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_DEL_HEAD = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DEL_TAIL = 3'd3;
   localparam logic [KIND_W-1:0] KIND_READ_FWD = 3'd4;
   localparam logic [KIND_W-1:0] KIND_READ_REV = 3'd5;

   // Result status codes.
   localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

   // Operation applied to the register chain.
   typedef enum logic [2:0] {
      OP_NONE,
      OP_INSERT,
      OP_DELETE,
      OP_ROT_LEFT,
      OP_ROT_RIGHT
   } list_op_type;

   // Source of the position used by insert and delete.
   typedef enum logic [1:0] {
      POS_REQ,
      POS_HEAD,
      POS_TAIL
   } pos_sel_type;

   // Source of the emitted value.
   typedef enum logic [1:0] {
      OUT_ZERO,
      OUT_HEAD,
      OUT_TAIL
   } out_sel_type;

   // Controller to datapath commands.
   typedef struct packed {
      list_op_type         op;
      pos_sel_type         pos_sel;
      logic                out_load;
      out_sel_type         out_sel;
      logic                out_has_value;
      logic [STAT_W-1:0]   out_status;
      logic                out_last;
   } dp_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic [LEN_W-1:0] count;
      logic             pos_ok;
   } dp_stat_type;

endpackage

`default_nettype wire

// ----- rtl/bple_datapath.sv -----
// Datapath of the list engine: the shifting register chain, the length
// register and the result payload registers. Depends on bple_pkg.
`default_nettype none

module bple_datapath
   import bple_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic [VAL_W-1:0]        req_item_value,
   input  wire logic [POS_W-1:0]        req_position,
   input  wire dp_cmd_type              cmd,
   output dp_stat_type                  stat,
   output logic signed [VAL_W-1:0]      rsp_out_value,
   output logic                         rsp_has_value,
   output logic [LEN_W-1:0]             rsp_length_now,
   output logic [STAT_W-1:0]            rsp_status,
   output logic                         rsp_last
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [VAL_W-1:0]  entries_ff [CAPACITY];
   logic [VAL_W-1:0]  entries_in [CAPACITY];
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [LEN_W-1:0]  count_ext;
   logic [LEN_W-1:0]  pos_ext;
   logic [LEN_W-1:0]  eff_pos;
   logic [VAL_W-1:0]  tail_val;
   logic [VAL_W-1:0]  out_val;

   logic [VAL_W-1:0]  out_value_ff;
   logic              has_value_ff;
   logic [LEN_W-1:0]  length_ff;
   logic [STAT_W-1:0] status_ff;
   logic              last_ff;

   assign count_ext = LEN_W'(count_ff);
   assign pos_ext   = LEN_W'(req_position);

   // Status toward the controller.
   assign stat.count  = count_ext;
   assign stat.pos_ok = (pos_ext < count_ext);

   // Effective position; an insert past the tail is clamped to the tail.
   always_comb begin
      case (cmd.pos_sel)
         POS_HEAD: eff_pos = '0;
         POS_TAIL: eff_pos = count_ext - LEN_W'(1);
         default:  eff_pos = (pos_ext > count_ext) ? count_ext : pos_ext;
      endcase
   end

   // Each cell drives the tail bus when it holds the last element.
   always_comb begin
      tail_val = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (LEN_W'(i) + LEN_W'(1) == count_ext) begin
            tail_val = tail_val | entries_ff[i];
         end
      end
   end

   // Next value of every cell of the chain.
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         entries_in[i] = entries_ff[i];
         case (cmd.op)
            OP_INSERT: begin
               if (LEN_W'(i) == eff_pos) begin
                  entries_in[i] = req_item_value;
               end else if (LEN_W'(i) > eff_pos) begin
                  entries_in[i] = entries_ff[(i == 0) ? 0 : i - 1];
               end
            end
            OP_DELETE: begin
               if (LEN_W'(i) >= eff_pos) begin
                  entries_in[i] = entries_ff[(i == CAPACITY - 1) ? i : i + 1];
               end
            end
            OP_ROT_LEFT: begin
               if (LEN_W'(i) + LEN_W'(1) == count_ext) begin
                  entries_in[i] = entries_ff[0];
               end else begin
                  entries_in[i] = entries_ff[(i == CAPACITY - 1) ? i : i + 1];
               end
            end
            OP_ROT_RIGHT: begin
               if (i == 0) begin
                  entries_in[i] = tail_val;
               end else begin
                  entries_in[i] = entries_ff[(i == 0) ? 0 : i - 1];
               end
            end
            default: begin
               entries_in[i] = entries_ff[i];
            end
         endcase
      end
   end

   // Length update.
   always_comb begin
      case (cmd.op)
         OP_INSERT: count_in = count_ff + CNT_W'(1);
         OP_DELETE: count_in = count_ff - CNT_W'(1);
         default:   count_in = count_ff;
      endcase
   end

   // Emitted value selection.
   always_comb begin
      case (cmd.out_sel)
         OUT_HEAD: out_val = entries_ff[0];
         OUT_TAIL: out_val = tail_val;
         default:  out_val = '0;
      endcase
   end

   // Chain cells hold payload only and need no reset.
   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         entries_ff[i] <= entries_in[i];
      end
   end

   // Length register.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Result payload registers.
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_value_ff <= out_val;
         has_value_ff <= cmd.out_has_value;
         length_ff    <= LEN_W'(count_in);
         status_ff    <= cmd.out_status;
         last_ff      <= cmd.out_last;
      end
   end

   assign rsp_out_value  = out_value_ff;
   assign rsp_has_value  = has_value_ff;
   assign rsp_length_now = length_ff;
   assign rsp_status     = status_ff;
   assign rsp_last       = last_ff;

   // The length never exceeds the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ext <= LEN_W'(CAPACITY))
      else $error("list length above capacity");

   // An insert is only issued into a list that has room.
   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_INSERT) |-> (count_ext < LEN_W'(CAPACITY)))
      else $error("insert issued into a full list");

endmodule

`default_nettype wire

// ----- rtl/bple_controller.sv -----
// Controller of the list engine: command decode, read sequencing and the
// result valid flag. Depends on bple_pkg.
`default_nettype none

module bple_controller
   import bple_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [KIND_W-1:0] req_kind,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   input  wire dp_stat_type       stat,
   output dp_cmd_type             cmd
);

   localparam int IDX_W = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;

   typedef enum logic [2:0] {
      ST_IDLE     = 3'b001,
      ST_READ_FWD = 3'b010,
      ST_READ_REV = 3'b100
   } state_type;

   state_type        state_ff;
   state_type        state_in;
   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] idx_in;
   logic             valid_ff;
   logic             valid_in;
   logic             slot_free;
   logic             accept;
   logic             last_elem;
   logic             list_empty;
   logic             list_full;

   assign slot_free  = !valid_ff || rsp_ready;
   assign req_ready  = (state_ff == ST_IDLE) && slot_free;
   assign accept     = req_valid && req_ready;
   assign last_elem  = (LEN_W'(idx_ff) + LEN_W'(1) == stat.count);
   assign list_empty = (stat.count == '0);
   assign list_full  = (stat.count == LEN_W'(CAPACITY));
   assign rsp_valid  = valid_ff;

   // Next state, commands and result valid.
   always_comb begin
      state_in          = state_ff;
      idx_in            = idx_ff;
      cmd.op            = OP_NONE;
      cmd.pos_sel       = POS_REQ;
      cmd.out_load      = 1'b0;
      cmd.out_sel       = OUT_ZERO;
      cmd.out_has_value = 1'b0;
      cmd.out_status    = STAT_DONE;
      cmd.out_last      = 1'b1;

      unique case (state_ff) inside
         ST_IDLE: begin
            if (accept) begin
               cmd.out_load = 1'b1;
               unique case (req_kind) inside
                  KIND_INSERT: begin
                     if (list_full) begin
                        cmd.out_status = STAT_FULL;
                     end else begin
                        cmd.op = OP_INSERT;
                     end
                  end
                  KIND_DEL_POS: begin
                     if (stat.pos_ok) begin
                        cmd.op = OP_DELETE;
                     end else begin
                        cmd.out_status = STAT_RANGE;
                     end
                  end
                  KIND_DEL_HEAD: begin
                     cmd.pos_sel = POS_HEAD;
                     if (list_empty) begin
                        cmd.out_status = STAT_RANGE;
                     end else begin
                        cmd.op = OP_DELETE;
                     end
                  end
                  KIND_DEL_TAIL: begin
                     cmd.pos_sel = POS_TAIL;
                     if (list_empty) begin
                        cmd.out_status = STAT_RANGE;
                     end else begin
                        cmd.op = OP_DELETE;
                     end
                  end
                  KIND_READ_FWD, KIND_READ_REV: begin
                     // An empty list answers with a single empty marker.
                     if (!list_empty) begin
                        cmd.out_load = 1'b0;
                        idx_in       = '0;
                        state_in     = (req_kind == KIND_READ_FWD) ? ST_READ_FWD
                                                                   : ST_READ_REV;
                     end
                  end
                  default: begin
                     cmd.op = OP_NONE;
                  end
               endcase
            end
         end
         ST_READ_FWD, ST_READ_REV: begin
            // Emit one element per free output slot and rotate the chain,
            // so the list is back in order after the final element.
            if (slot_free) begin
               cmd.out_load      = 1'b1;
               cmd.out_has_value = 1'b1;
               cmd.out_last      = last_elem;
               if (state_ff == ST_READ_FWD) begin
                  cmd.out_sel = OUT_HEAD;
                  cmd.op      = OP_ROT_LEFT;
               end else begin
                  cmd.out_sel = OUT_TAIL;
                  cmd.op      = OP_ROT_RIGHT;
               end
               idx_in = idx_ff + IDX_W'(1);
               if (last_elem) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      valid_in = cmd.out_load || (valid_ff && !rsp_ready);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // The read index stays inside the list during a read.
   a_idx_in_list: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (LEN_W'(idx_ff) < stat.count))
      else $error("read index outside the list");

   // The list length does not change while a read is in progress.
   a_len_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> $stable(stat.count))
      else $error("list length changed during a read");

   // Emitting the final element of a read returns the controller to idle.
   a_read_ends: assert property (@(posedge clock) disable iff (reset)
      ((state_ff != ST_IDLE) && cmd.out_load && cmd.out_last) |=>
      (state_ff == ST_IDLE))
      else $error("read did not end after its final element");

   // A new command is never taken while a result is stuck in the output register.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> !(valid_ff && !rsp_ready))
      else $error("command accepted over a pending result");

endmodule

`default_nettype wire

// ----- rtl/bounded_positional_list_engine_unit.sv -----
// Top level of the bounded positional list engine.
// Depends on bple_pkg, bple_controller and bple_datapath.
`default_nettype none

// Ordered list of up to CAPACITY signed 32-bit values held in a chain of
// registers. One command is worked on at a time. Insert and the three
// delete forms shift the chain in the cycle the command is transferred,
// and their single result is ready in the output register the cycle after;
// a new command can be transferred in the cycle that result is taken, so
// these run at one command per cycle while no result stalls. A read of
// an n-entry list gives n results, one element per cycle after the
// transfer cycle while the output does not stall, as the chain rotates by
// one place, which leaves the list in its original order after the final
// element. Reads of an empty list and unused kinds give one result like an
// insert. Reset clears only the length register and the control registers.
module bounded_positional_list_engine_unit
   import bple_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [KIND_W-1:0]   req_kind,
   input  wire logic signed [VAL_W-1:0] req_item_value,
   input  wire logic [POS_W-1:0]    req_position,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic signed [VAL_W-1:0]  rsp_out_value,
   output logic                     rsp_has_value,
   output logic [LEN_W-1:0]         rsp_length_now,
   output logic [STAT_W-1:0]        rsp_status,
   output logic                     rsp_last
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // Command decode and read sequencing.
   bple_controller #(
      .CAPACITY (CAPACITY)
   ) u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_kind),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Register chain and result payload.
   bple_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_item_value (req_item_value),
      .req_position   (req_position),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_out_value  (rsp_out_value),
      .rsp_has_value  (rsp_has_value),
      .rsp_length_now (rsp_length_now),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire

// ----- verif/bounded_positional_list_engine_unit_tb.sv -----
// Self-checking testbench for bounded_positional_list_engine_unit.
// Depends on bple_pkg and the engine RTL. A scoreboard class predicts each result
// from an in-order copy of the list, and the responses are checked against it.

module bounded_positional_list_engine_unit_tb;
   import bple_pkg::*;

   localparam int LIST_CAPACITY = 16;

   // Kinds the block treats as no operation.
   localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
   localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;

   // One response as the block should present it.
   typedef struct {
      logic signed [VAL_W-1:0] value;
      logic                    has_value;
      logic [LEN_W-1:0]        length;
      logic [STAT_W-1:0]       status;
      logic                    last;
   } list_result_type;

   // Scoreboard: keeps its own copy of the list and a queue of expected responses.
   class list_scoreboard;
      logic signed [VAL_W-1:0] contents[$];
      list_result_type         expected_q[$];
      int errors;
      int commands;
      int results;
      int full_drops;
      int range_flags;
      int reads;

      function new();
         errors      = 0;
         commands    = 0;
         results     = 0;
         full_drops  = 0;
         range_flags = 0;
         reads       = 0;
      endfunction

      function int outstanding();
         return expected_q.size();
      endfunction

      function int list_length();
         return contents.size();
      endfunction

      task report(input string what);
         errors++;
         $display("MISMATCH at %0t: %s", $realtime, what);
      endtask

      // Queue one response with no list element.
      function void push_single(input logic [STAT_W-1:0] status);
         list_result_type r;
         r.value     = '0;
         r.has_value = 1'b0;
         r.length    = LEN_W'(contents.size());
         r.status    = status;
         r.last      = 1'b1;
         if (status == STAT_FULL) full_drops++;
         if (status == STAT_RANGE) range_flags++;
         expected_q.push_back(r);
      endfunction

      // Apply one transferred command to the list copy and queue its responses.
      function void note_transfer(input logic [KIND_W-1:0] kind,
                                  input logic signed [VAL_W-1:0] value,
                                  input logic [POS_W-1:0] pos);
         list_result_type r;
         int n;
         int p;
         int i;
         n = contents.size();
         p = int'(pos);
         commands++;
         case (kind) inside
            KIND_INSERT: begin
               if (n >= LIST_CAPACITY) begin
                  push_single(STAT_FULL);
               end else begin
                  // A position at or past the length appends at the tail.
                  if (p > n) p = n;
                  contents.insert(p, value);
                  push_single(STAT_DONE);
               end
            end
            KIND_DEL_POS: begin
               if (p < n) begin
                  contents.delete(p);
                  push_single(STAT_DONE);
               end else begin
                  push_single(STAT_RANGE);
               end
            end
            KIND_DEL_HEAD, KIND_DEL_TAIL: begin
               if (n == 0) begin
                  push_single(STAT_RANGE);
               end else begin
                  contents.delete((kind == KIND_DEL_HEAD) ? 0 : n - 1);
                  push_single(STAT_DONE);
               end
            end
            KIND_READ_FWD, KIND_READ_REV: begin
               reads++;
               if (n == 0) begin
                  push_single(STAT_DONE);
               end else begin
                  for (i = 0; i < n; i++) begin
                     r.value     = contents[(kind == KIND_READ_FWD) ? i : n - 1 - i];
                     r.has_value = 1'b1;
                     r.length    = LEN_W'(n);
                     r.status    = STAT_DONE;
                     r.last      = (i == n - 1);
                     expected_q.push_back(r);
                  end
               end
            end
            default: begin
               push_single(STAT_DONE);
            end
         endcase
      endfunction

      // Compare one accepted response with the oldest expectation.
      task check_result(input logic signed [VAL_W-1:0] value, input logic has_value,
                        input logic [LEN_W-1:0] length, input logic [STAT_W-1:0] status,
                        input logic last);
         list_result_type e;
         results++;
         if (expected_q.size() == 0) begin
            report($sformatf("response %0d arrived with nothing expected", results));
         end else begin
            e = expected_q.pop_front();
            if (value !== e.value)
               report($sformatf("response %0d out_value %0d, expected %0d",
                                results, value, e.value));
            if (has_value !== e.has_value)
               report($sformatf("response %0d has_value %0b, expected %0b",
                                results, has_value, e.has_value));
            if (length !== e.length)
               report($sformatf("response %0d length_now %0d, expected %0d",
                                results, length, e.length));
            if (status !== e.status)
               report($sformatf("response %0d status %0d, expected %0d",
                                results, status, e.status));
            if (last !== e.last)
               report($sformatf("response %0d last %0b, expected %0b",
                                results, last, e.last));
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                    req_valid      = 1'b0;
   logic                    req_ready;
   logic [KIND_W-1:0]       req_kind       = '0;
   logic signed [VAL_W-1:0] req_item_value = '0;
   logic [POS_W-1:0]        req_position   = '0;
   logic                    rsp_valid;
   logic                    rsp_ready      = 1'b0;
   logic signed [VAL_W-1:0] rsp_out_value;
   logic                    rsp_has_value;
   logic [LEN_W-1:0]        rsp_length_now;
   logic [STAT_W-1:0]       rsp_status;
   logic                    rsp_last;

   // Flags that steer the response side from the command process.
   bit hold_request = 1'b0;
   bit quiet_mode   = 1'b0;

   list_scoreboard sb = new();

   bounded_positional_list_engine_unit #(
      .CAPACITY(LIST_CAPACITY)
   ) u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_item_value(req_item_value),
      .req_position  (req_position),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_value (rsp_out_value),
      .rsp_has_value (rsp_has_value),
      .rsp_length_now(rsp_length_now),
      .rsp_status    (rsp_status),
      .rsp_last      (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Check every response transfer.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_out_value, rsp_has_value, rsp_length_now, rsp_status, rsp_last);
   end

   // Response side: random stall bursts, one long hold-off on request, none at the end.
   initial begin
      forever begin
         if (quiet_mode) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_request = 1'b0;
         end else if ($urandom_range(0, 2) != 0) begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
   end

   // Offer one command, optionally after an idle burst, and wait for its transfer.
   task automatic issue(input logic [KIND_W-1:0] kind, input logic signed [VAL_W-1:0] value,
                        input logic [POS_W-1:0] pos, input int idle_pct);
      if (!quiet_mode && $urandom_range(1, 100) <= idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_item_value <= value;
      req_position   <= pos;
      do @(posedge clock); while (!req_ready);
      sb.note_transfer(kind, value, pos);
   endtask

   // Pick a random command with the given mix of inserts and deletes; the rest are reads and unused kinds.
   task automatic random_command(input int ins_pct, input int del_pct, input int idle_pct);
      logic [KIND_W-1:0] kind;
      logic [POS_W-1:0]  pos;
      int r;
      r = $urandom_range(0, 99);
      if (r < ins_pct)
         kind = KIND_INSERT;
      else if (r < ins_pct + del_pct)
         kind = (r % 3 == 0) ? KIND_DEL_POS : (r % 3 == 1) ? KIND_DEL_HEAD : KIND_DEL_TAIL;
      else if (r < 96)
         kind = r[0] ? KIND_READ_FWD : KIND_READ_REV;
      else
         kind = r[0] ? KIND_SPARE_7 : KIND_SPARE_6;
      // Mostly positions from zero to the current length, sometimes anywhere in the field.
      if ($urandom_range(0, 3) == 0)
         pos = POS_W'($urandom_range(0, 63));
      else
         pos = POS_W'($urandom_range(0, sb.list_length()));
      issue(kind, $urandom, pos, idle_pct);
   endtask

   // Stop offering commands until every expected response has been taken.
   task automatic drain_wait();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
   endtask

   // Main stimulus sequence.
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty-list cases, unused kinds, extreme values, edge positions.
      issue(KIND_READ_FWD, 0, 0, 0);
      issue(KIND_READ_REV, 0, 0, 0);
      issue(KIND_DEL_HEAD, 0, 0, 0);
      issue(KIND_DEL_TAIL, 0, 0, 0);
      issue(KIND_DEL_POS, 0, 0, 0);
      issue(KIND_SPARE_6, 0, 0, 0);
      issue(KIND_SPARE_7, -1, 6'd63, 0);
      issue(KIND_INSERT, 32'sh7FFF_FFFF, 0, 0);
      issue(KIND_INSERT, 32'sh8000_0000, 6'd63, 0);
      issue(KIND_INSERT, 0, 1, 0);
      issue(KIND_INSERT, -1, 0, 0);
      issue(KIND_INSERT, 1, 2, 0);
      issue(KIND_READ_FWD, 0, 0, 0);
      issue(KIND_READ_REV, 0, 0, 0);
      issue(KIND_DEL_POS, 0, 6'd63, 0);
      issue(KIND_DEL_POS, 0, 5, 0);
      issue(KIND_DEL_POS, 0, 2, 0);
      issue(KIND_DEL_HEAD, 0, 0, 0);
      issue(KIND_DEL_TAIL, 0, 0, 0);
      issue(KIND_READ_FWD, 0, 0, 0);
      issue(KIND_DEL_POS, 0, 1, 0);
      issue(KIND_DEL_TAIL, 0, 0, 0);
      issue(KIND_READ_REV, 0, 0, 0);

      // Mixed traffic with idle bursts on both sides.
      repeat (30) random_command(45, 30, 30);

      // Hold the response side off while inserts keep coming, so the list fills
      // and overflows and the command side backs up.
      hold_request = 1'b1;
      repeat (18) issue(KIND_INSERT, $urandom, POS_W'($urandom_range(0, 63)), 0);
      issue(KIND_READ_FWD, 0, 0, 0);
      issue(KIND_READ_REV, 0, 0, 0);
      drain_wait();

      // Delete-heavy traffic to empty the list and hit rejected deletes.
      repeat (40) random_command(15, 60, 25);
      drain_wait();

      // Mixed traffic, then a final stretch with no idling at all.
      repeat (25) random_command(45, 30, 20);
      quiet_mode = 1'b1;
      repeat (20) random_command(50, 30, 0);

      drain_wait();
      repeat (20) @(posedge clock);

      $display("Covered %0d commands and %0d responses, including %0d list reads.",
               sb.commands, sb.results, sb.reads);
      $display("Inserts dropped on a full list: %0d; deletes rejected: %0d.",
               sb.full_drops, sb.range_flags);
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #4_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
